FILE: hw/rtl/gsbp_pkg.sv
// ----------------------------------------------------------------------------
// gsbp_pkg
// Shared types, constants and the counter update function of the
// gselect branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbp_pkg;

   localparam int HISTORY_BITS_DEFAULT       = 3;
   localparam int ADDRESS_INDEX_BITS_DEFAULT = 4;
   localparam int INDEX_BITS_DEFAULT         = HISTORY_BITS_DEFAULT
                                               + ADDRESS_INDEX_BITS_DEFAULT;
   localparam int BYTE_OFFSET_BITS           = 2;
   localparam int ADDRESS_BITS               = 32;
   localparam int COUNT_BITS                 = 32;

   typedef logic [1:0] counter_type;

   // weakly not taken
   localparam counter_type COUNTER_RESET = 2'b01;

   localparam logic ACTION_PREDICT = 1'b0;
   localparam logic ACTION_RESOLVE = 1'b1;

   // taken: 00->01, 01->11, 10->11, 11->11
   // not taken: 11->10, others ->00
   function automatic counter_type next_counter(input counter_type c, input logic taken);
      counter_type n;
      unique case (c)
         2'b00:   n = taken ? 2'b01 : 2'b00;
         2'b01:   n = taken ? 2'b11 : 2'b00;
         2'b10:   n = taken ? 2'b11 : 2'b00;
         default: n = taken ? 2'b11 : 2'b10;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gsbp_if.sv
// ----------------------------------------------------------------------------
// gsbp_req_if / gsbp_rsp_if
// Valid/ready channels for predictor requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsbp_req_if
   import gsbp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [ADDRESS_BITS-1:0] branch_pc;
   logic [INDEX_BITS-1:0]   resolve_index;
   logic                    actual_taken;

   modport source (
      output valid, action, branch_pc, resolve_index, actual_taken,
      input  ready
   );
   modport sink (
      input  valid, action, branch_pc, resolve_index, actual_taken,
      output ready
   );
endinterface

interface gsbp_rsp_if
   import gsbp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  predicted_taken;
   logic [INDEX_BITS-1:0] table_index;
   logic                  mispredicted;
   logic [COUNT_BITS-1:0] resolved_count;
   logic [COUNT_BITS-1:0] correct_count;

   modport source (
      output valid, predicted_taken, table_index, mispredicted, resolved_count,
             correct_count,
      input  ready
   );
   modport sink (
      input  valid, predicted_taken, table_index, mispredicted, resolved_count,
             correct_count,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/gsbp_table.sv
// ----------------------------------------------------------------------------
// gsbp_table
// Counter memory: one synchronous read port, one write port, and a
// clearing sweep after reset that loads every entry with the reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbp_table
   import gsbp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [INDEX_BITS-1:0] rd_addr,
   output      counter_type           rd_data,
   input  wire logic                  wr_en,
   input  wire logic [INDEX_BITS-1:0] wr_addr,
   input  wire counter_type           wr_data,
   output      logic                  clear_busy
);

   localparam int DEPTH = 1 << INDEX_BITS;

   counter_type           mem_ff [DEPTH];
   counter_type           rd_data_ff;
   logic [INDEX_BITS-1:0] clear_addr_ff, clear_addr_in;
   logic                  clearing_ff, clearing_in;

   logic                  mem_we;
   logic [INDEX_BITS-1:0] mem_waddr;
   counter_type           mem_wdata;

   always_comb begin
      clear_addr_in = clear_addr_ff;
      clearing_in   = clearing_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (&clear_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = COUNTER_RESET;
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         clearing_ff   <= 1'b1;
      end else begin
         clear_addr_ff <= clear_addr_in;
         clearing_ff   <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/gselect_branch_predictor.sv
// ----------------------------------------------------------------------------
// gselect_branch_predictor
// gselect predictor: 2-bit counters indexed by global history joined above
// instruction address bits, with predict and resolve transactions.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  req_chan  | in  | valid / ready | action, branch_pc,
//            |     |               | resolve_index, actual_taken
//  rsp_chan  | out | valid / ready | predicted_taken, table_index, mispredicted,
//            |     |               | resolved_count, correct_count
//
//  A transaction passes through ST_IDLE, where acceptance issues the counter
//  memory read, and ST_LOOKUP, which updates memory/history/totals and loads
//  the response. The single memory read port returns registered data.
//  After reset a clearing pass writes all 2^(HISTORY_BITS+ADDRESS_INDEX_BITS)
//  entries (128 by default); req_chan.ready stays low meanwhile.
//  A request may be accepted while a response waits; the update then holds
//  until the response register frees up.
//
`default_nettype none

module gselect_branch_predictor
   import gsbp_pkg::*;
#(
   parameter int HISTORY_BITS       = HISTORY_BITS_DEFAULT,
   parameter int ADDRESS_INDEX_BITS = ADDRESS_INDEX_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   gsbp_req_if.sink   req_chan,
   gsbp_rsp_if.source rsp_chan
);

   localparam int INDEX_BITS = HISTORY_BITS + ADDRESS_INDEX_BITS;

   // control states
   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic state_ff, state_in;

   // transaction held during lookup
   logic                  action_ff;
   logic                  taken_ff;
   logic [INDEX_BITS-1:0] idx_ff;

   logic [HISTORY_BITS-1:0] history_ff, history_in;
   logic [COUNT_BITS-1:0]   resolved_ff, resolved_in;
   logic [COUNT_BITS-1:0]   correct_ff, correct_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_pred_ff;
   logic [INDEX_BITS-1:0] rsp_idx_ff;
   logic                  rsp_miss_ff;
   logic [COUNT_BITS-1:0] rsp_resolved_ff;
   logic [COUNT_BITS-1:0] rsp_correct_ff;

   logic                  clear_busy;
   logic                  req_fire;
   logic                  finish;
   logic [INDEX_BITS-1:0] req_idx;
   logic [INDEX_BITS-1:0] rd_addr;
   counter_type           rd_data;
   logic                  miss;
   logic                  wr_en;
   counter_type           wr_data;

   assign req_chan.ready = (state_ff == ST_IDLE) && !clear_busy;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // predict index: history above address bits just past the byte offset
   always_comb begin
      if (req_chan.action == ACTION_RESOLVE) begin
         req_idx = req_chan.resolve_index;
      end else begin
         req_idx = {history_ff,
                    req_chan.branch_pc[BYTE_OFFSET_BITS +: ADDRESS_INDEX_BITS]};
      end
   end

   // keep the read address pointing at the held entry so data stays fresh
   assign rd_addr = req_fire ? req_idx : idx_ff;

   gsbp_table #(
      .INDEX_BITS (INDEX_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (idx_ff),
      .wr_data    (wr_data),
      .clear_busy (clear_busy)
   );

   // lookup completes once the response slot is free
   assign finish  = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);
   assign miss    = (action_ff == ACTION_RESOLVE) && (rd_data[1] != taken_ff);
   assign wr_en   = finish && (action_ff == ACTION_RESOLVE);
   assign wr_data = next_counter(rd_data, taken_ff);

   always_comb begin
      state_in    = state_ff;
      history_in  = history_ff;
      resolved_in = resolved_ff;
      correct_in  = correct_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         default: begin
            if (finish) begin
               state_in = ST_IDLE;
               if (action_ff == ACTION_RESOLVE) begin
                  // outcome enters history from the top
                  history_in                 = history_ff >> 1;
                  history_in[HISTORY_BITS-1] = taken_ff;
                  resolved_in                = resolved_ff + 1'b1;
                  if (!miss) begin
                     correct_in = correct_ff + 1'b1;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         history_ff   <= '0;
         resolved_ff  <= '0;
         correct_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         history_ff   <= history_in;
         resolved_ff  <= resolved_in;
         correct_ff   <= correct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_chan.action;
         taken_ff  <= req_chan.actual_taken;
         idx_ff    <= req_idx;
      end
      if (finish) begin
         rsp_pred_ff     <= rd_data[1];
         rsp_idx_ff      <= idx_ff;
         rsp_miss_ff     <= miss;
         rsp_resolved_ff <= resolved_in;
         rsp_correct_ff  <= correct_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.predicted_taken = rsp_pred_ff;
   assign rsp_chan.table_index     = rsp_idx_ff;
   assign rsp_chan.mispredicted    = rsp_miss_ff;
   assign rsp_chan.resolved_count  = rsp_resolved_ff;
   assign rsp_chan.correct_count   = rsp_correct_ff;

endmodule

`default_nettype wire
